[hdl/phx_pkg.sv]
// ----------------------------------------------------------------------------
// phx_pkg - shared types and constants for the Philox counter RNG
// Beat payload structs, the per-stage lane struct, and the round constants.
// ----------------------------------------------------------------------------
package phx_pkg;

  // Default round count
  localparam int ROUNDS_DEFAULT = 10;

  // Philox-4x32 multipliers and Weyl key increments
  localparam logic [31:0] MUL_A     = 32'hD251_1F53;
  localparam logic [31:0] MUL_B     = 32'hCD9E_8D57;
  localparam logic [31:0] WEYL_A    = 32'h9E37_79B9;
  localparam logic [31:0] WEYL_B    = 32'hBB67_AE85;
  localparam logic [31:0] KEY_TWEAK = 32'hDEAD_BEEF;

  // Request beat
  typedef struct packed {
    logic [31:0] seed;
    logic [31:0] counter;
  } req_t;

  // Response beat
  typedef struct packed {
    logic [31:0] raw_word;
    logic [31:0] unit_value;
  } rsp_t;

  // One pipeline stage: valid bit, seed for key derivation, counter block
  typedef struct packed {
    logic        valid;
    logic [31:0] seed;
    logic [31:0] c0;
    logic [31:0] c1;
    logic [31:0] c2;
    logic [31:0] c3;
  } lane_t;

endpackage

[hdl/phx_round.sv]
// ----------------------------------------------------------------------------
// phx_round - one registered Philox round
// Two 32x32 multiplies, word swap with key XOR; key for this round is
// derived from the seed plus a per-stage multiple of the Weyl constants.
// ----------------------------------------------------------------------------
module phx_round #(
  parameter int STAGE = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  phx_pkg::lane_t lane_in,
  output phx_pkg::lane_t lane_out
);

  // Key offsets for this round, folded at elaboration
  localparam logic [63:0] OFS_A_W = 64'(STAGE) * {32'd0, phx_pkg::WEYL_A};
  localparam logic [63:0] OFS_B_W = 64'(STAGE) * {32'd0, phx_pkg::WEYL_B};
  localparam logic [31:0] OFS_A   = OFS_A_W[31:0];
  localparam logic [31:0] OFS_B   = OFS_B_W[31:0];

  logic [63:0]    prod_a;
  logic [63:0]    prod_b;
  logic [31:0]    key0;
  logic [31:0]    key1;
  phx_pkg::lane_t lane_next;

  // Round keys
  assign key0 = lane_in.seed + OFS_A;
  assign key1 = (lane_in.seed ^ phx_pkg::KEY_TWEAK) + OFS_B;

  // Unsigned full products
  assign prod_a = {32'd0, phx_pkg::MUL_A} * {32'd0, lane_in.c0};
  assign prod_b = {32'd0, phx_pkg::MUL_B} * {32'd0, lane_in.c2};

  // Swap and mix
  always_comb begin
    lane_next       = lane_in;
    lane_next.c0    = prod_b[63:32] ^ lane_in.c1 ^ key0;
    lane_next.c1    = prod_b[31:0];
    lane_next.c2    = prod_a[63:32] ^ lane_in.c3 ^ key1;
    lane_next.c3    = prod_a[31:0];
  end

  // Stage register; only the valid bit is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      lane_out.valid <= 1'b0;
    end else if (en) begin
      lane_out <= lane_next;
    end
  end

endmodule

[hdl/philox_counter_rng.sv]
// ----------------------------------------------------------------------------
// philox_counter_rng - stateless Philox-4x32 random word generator
// An accepted request beat passes the entry register, ROUNDS round registers and the output register.
// Throughput: one beat per cycle while the response is not stalled; one round per stage, one multiplier pair each.
// A stalled response holds the whole pipeline in place; bubbles are kept.
// Reset clears the valid bits of every stage; there is no other state.
// ----------------------------------------------------------------------------
module philox_counter_rng #(
  parameter int ROUNDS = phx_pkg::ROUNDS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  phx_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output phx_pkg::rsp_t rsp
);

  phx_pkg::lane_t lane [ROUNDS+1];
  logic           en;
  logic [31:0]    raw_next;
  logic [31:0]    unit_next;

  // Pipeline advances unless a finished beat is held at the output
  assign en        = !(rsp_valid && rsp_stall);
  assign req_stall = !en;

  // Entry stage: counter block {counter, 0, 0, 0}
  always_ff @(posedge clk) begin
    if (rst) begin
      lane[0].valid <= 1'b0;
    end else if (en) begin
      lane[0].valid <= req_valid;
      lane[0].seed  <= req.seed;
      lane[0].c0    <= req.counter;
      lane[0].c1    <= 32'd0;
      lane[0].c2    <= 32'd0;
      lane[0].c3    <= 32'd0;
    end
  end

  // Round stages
  for (genvar g = 0; g < ROUNDS; g++) begin : g_round
    phx_round #(
      .STAGE (g)
    ) u_round (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .lane_in  (lane[g]),
      .lane_out (lane[g+1])
    );
  end

  // Output word and its magnitude; |r| is the exact unsigned Q1.31 magnitude of r read as signed Q1.31
  assign raw_next  = lane[ROUNDS].c0 ^ lane[ROUNDS].c2;
  assign unit_next = raw_next[31] ? (~raw_next + 32'd1) : raw_next;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid      <= lane[ROUNDS].valid;
      rsp.raw_word   <= raw_next;
      rsp.unit_value <= unit_next;
    end
  end

  // Assertions
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.unit_value <= 32'h8000_0000))
    else $error("unit_value above one");

  a_unit_pos: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.raw_word[31]) |-> (rsp.unit_value == rsp.raw_word))
    else $error("unit_value differs from non-negative raw word");

  a_unit_neg: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.raw_word[31]) |-> ((rsp.unit_value + rsp.raw_word) == 32'd0))
    else $error("unit_value is not the magnitude of a negative raw word");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (lane[ROUNDS].valid && req_stall) |=> lane[ROUNDS].valid)
    else $error("last round stage dropped a beat during stall");

endmodule
